// ----- design/gpdm_pkg.sv -----
package gpdm_pkg;

    localparam int DB_W   = 12;
    localparam int GAIN_W = 16;
    localparam int CH_W   = 3;

    localparam logic signed [DB_W-1:0] DB_FLOOR    = -12'sd960;
    localparam logic signed [DB_W-1:0] DB_MIN      = -12'sd1600;
    localparam logic signed [DB_W-1:0] LOUD_OFFSET = 12'sd8;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    localparam logic [CH_W-1:0] CH_LEFT  = 3'd0;
    localparam logic [CH_W-1:0] CH_RIGHT = 3'd1;

    typedef struct packed {
        logic                   done;
        logic signed [DB_W-1:0] db;
    } conv_rsp_t;

endpackage

// ----- design/gain_and_peak_db_meter_top.sv -----
// Channel  Dir  Handshake            Contents
// s_*      in   s_tvalid / s_tready  s_tdata: sample_in, channel_index; s_tlast: block_end
// m_*      out  m_tvalid / m_tready  m_tdata: sample, left, right, loudness; m_tuser: valid
// cfg_*    in   cfg_wr_en            cfg_index selects running or master_gain, cfg_data
//
// Samples pass through the gain stage register and then enter a four-entry queue; plain
// items leave at one per clock when the output side is free, so input keeps flowing
// while the output side stalls, until the queue and the gain stage register are full.
// An item that closes a block while running holds the output side until the shared log2
// unit has turned both peaks into decibels, each by normalizing shifts and sixteen squarings.
// Reset stops the block, sets unity gain, clears the peaks and sets the meters to -60 dB.
module gain_and_peak_db_meter_top
    import gpdm_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int IN_W        = ((SAMPLE_BITS + CH_W + 7) / 8) * 8,
    localparam int OUT_W       = ((SAMPLE_BITS + 3 * DB_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // sample_in, channel_index
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // sample_out, left_peak_db, right_peak_db, loudness_db
    output logic              m_tuser,   // meters_valid
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    localparam int ENTRY_W     = 3 * SAMPLE_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam logic REG_RUNNING = 1'b0;
    localparam logic REG_GAIN    = 1'b1;

    logic                    running_reg, running_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;

    logic                    push;
    logic [ENTRY_W-1:0]      push_data;
    logic                    q_pop;
    logic [ENTRY_W-1:0]      q_data;
    logic                    q_full;
    logic                    q_empty;
    logic                    conv_start;
    logic [SAMPLE_BITS-1:0]  conv_mag;
    conv_rsp_t               conv_rsp;

    always_comb
    begin
        running_next = running_reg;
        gain_next    = gain_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RUNNING:
                begin
                    running_next = cfg_data[0];
                end
                REG_GAIN:
                begin
                    gain_next = (cfg_data > GAIN_MAX) ? GAIN_MAX : cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            gain_reg    <= GAIN_RESET;
        end
        else
        begin
            running_reg <= running_next;
            gain_reg    <= gain_next;
        end
    end

    gpdm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .running       (running_reg),
        .gain          (gain_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .sample_in     ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .channel_index (s_tdata[SAMPLE_BITS+CH_W-1:SAMPLE_BITS]),
        .block_end     (s_tlast),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    gpdm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head_data (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gpdm_db_conv #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_db_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (conv_mag),
        .rsp   (conv_rsp)
    );

    gpdm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .conv_start (conv_start),
        .conv_mag   (conv_mag),
        .conv_rsp   (conv_rsp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_user   (m_tuser)
    );

endmodule

// ----- design/gpdm_front.sv -----
module gpdm_front
    import gpdm_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int ENTRY_W     = 3 * SAMPLE_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          running,
    input  logic [GAIN_W-1:0]             gain,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [CH_W-1:0]               channel_index,
    input  logic                          block_end,
    output logic                          push,
    output logic [ENTRY_W-1:0]            push_data,
    input  logic                          q_full
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int Q_W    = SAMPLE_BITS + 3;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(8192);

    logic                          s1_valid_reg, s1_valid_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic [CH_W-1:0]               ch_reg;
    logic                          last_reg;
    logic [SAMPLE_BITS-1:0]        left_peak_reg, left_peak_next;
    logic [SAMPLE_BITS-1:0]        right_peak_reg, right_peak_next;

    logic                          accept;
    logic [Q_W-1:0]                q_val;
    logic [3:0]                    q_top;
    logic [SAMPLE_BITS-1:0]        y_gain;
    logic [SAMPLE_BITS-1:0]        y;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SAMPLE_BITS-1:0]        left_upd;
    logic [SAMPLE_BITS-1:0]        right_upd;
    logic                          upd;

    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !q_full;

    assign prod_next = sample_in * $signed({1'b0, gain}) + ROUND_HALF;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Rounding adds half an LSB before the arithmetic shift; overflow shows as unequal top bits.
    assign q_val = prod_reg[PROD_W-1:14];
    assign q_top = q_val[Q_W-1:SAMPLE_BITS-1];

    always_comb
    begin
        if ((&q_top) || !(|q_top))
        begin
            y_gain = q_val[SAMPLE_BITS-1:0];
        end
        else if (q_top[3])
        begin
            y_gain = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y_gain = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign y   = running ? y_gain : samp_reg;
    assign mag = y[SAMPLE_BITS-1] ? (~y + 1'b1) : y;

    always_comb
    begin
        left_upd  = left_peak_reg;
        right_upd = right_peak_reg;
        upd       = 1'b0;
        if (push && running)
        begin
            if (ch_reg == CH_LEFT && mag > left_peak_reg)
            begin
                left_upd = mag;
            end
            if (ch_reg == CH_RIGHT && mag > right_peak_reg)
            begin
                right_upd = mag;
            end
            upd = last_reg;
        end
        left_peak_next  = upd ? '0 : left_upd;
        right_peak_next = upd ? '0 : right_upd;
        push_data       = {upd, right_upd, left_upd, y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            left_peak_reg  <= '0;
            right_peak_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            left_peak_reg  <= left_peak_next;
            right_peak_reg <= right_peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod_next;
            samp_reg <= sample_in;
            ch_reg   <= channel_index;
            last_reg <= block_end;
        end
    end

endmodule

// ----- design/gpdm_queue.sv -----
module gpdm_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/gpdm_db_conv.sv -----
module gpdm_db_conv
    import gpdm_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] mag,
    output conv_rsp_t              rsp
);

    localparam int EW     = $clog2(SAMPLE_BITS);
    localparam int FRAC_W = 16;
    localparam int NLW    = EW + FRAC_W;
    localparam int SCALE_W = 23;
    localparam int PRW    = NLW + SCALE_W + 1;
    localparam int QW     = PRW - 32;
    localparam logic [SAMPLE_BITS-1:0] THRESH =
        SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) / 64'd100000);
    localparam logic [EW-1:0]      E_TOP     = EW'(SAMPLE_BITS - 1);
    localparam logic [SCALE_W-1:0] DB_SCALE  = 23'd6313057;
    localparam logic [PRW-1:0]     ROUND_Q   = PRW'(64'd1 << 31);
    localparam logic [QW-1:0]      MIN_MAG   = QW'(1600);
    localparam logic [3:0]         ITER_LAST = 4'd15;

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_NORM = 6'b000010,
        C_SQ   = 6'b000100,
        C_NRM  = 6'b001000,
        C_MUL  = 6'b010000,
        C_FIN  = 6'b100000
    } conv_state_t;

    conv_state_t         state_reg, state_next;
    logic [31:0]         x_reg, x_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [3:0]          iter_reg, iter_next;
    logic [63:0]         sq_reg, sq_next;
    logic [PRW-1:0]      prod_reg, prod_next;
    logic                floor_reg, floor_next;

    logic [32:0]         xs;
    logic [NLW-1:0]      nl;
    logic [QW-1:0]       q;

    assign xs = sq_reg[63:31];
    assign nl = {E_TOP - e_reg, {FRAC_W{1'b0}}} - NLW'(frac_reg);
    assign q  = prod_reg[PRW-1:32];

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        e_next     = e_reg;
        frac_next  = frac_reg;
        iter_next  = iter_reg;
        sq_next    = sq_reg;
        prod_next  = prod_reg;
        floor_next = floor_reg;
        unique case (state_reg)
            C_IDLE, C_FIN:
            begin
                if (start)
                begin
                    floor_next = mag <= THRESH;
                    x_next     = 32'(mag) << (32 - SAMPLE_BITS);
                    e_next     = E_TOP;
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = (mag <= THRESH) ? C_FIN : C_NORM;
                end
                else
                begin
                    state_next = C_IDLE;
                end
            end
            C_NORM:
            begin
                if (x_reg[31])
                begin
                    state_next = C_SQ;
                end
                else
                begin
                    x_next = x_reg << 1;
                    e_next = e_reg - 1'b1;
                end
            end
            C_SQ:
            begin
                sq_next    = 64'(x_reg) * 64'(x_reg);
                state_next = C_NRM;
            end
            C_NRM:
            begin
                frac_next = {frac_reg[FRAC_W-2:0], xs[32]};
                x_next    = xs[32] ? xs[32:1] : xs[31:0];
                if (iter_reg == ITER_LAST)
                begin
                    state_next = C_MUL;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = C_SQ;
                end
            end
            C_MUL:
            begin
                prod_next  = PRW'(nl) * PRW'(DB_SCALE) + ROUND_Q;
                state_next = C_FIN;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = state_reg == C_FIN;
        if (floor_reg)
        begin
            rsp.db = DB_FLOOR;
        end
        else if (q > MIN_MAG)
        begin
            rsp.db = DB_MIN;
        end
        else
        begin
            rsp.db = -$signed(DB_W'(q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        e_reg     <= e_next;
        frac_reg  <= frac_next;
        iter_reg  <= iter_next;
        sq_reg    <= sq_next;
        prod_reg  <= prod_next;
        floor_reg <= floor_next;
    end

endmodule

// ----- design/gpdm_back.sv -----
module gpdm_back
    import gpdm_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int ENTRY_W     = 3 * SAMPLE_BITS + 1,
    localparam int OUT_W       = ((SAMPLE_BITS + 3 * DB_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [ENTRY_W-1:0]     q_data,
    output logic                   q_pop,
    output logic                   conv_start,
    output logic [SAMPLE_BITS-1:0] conv_mag,
    input  conv_rsp_t              conv_rsp,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       out_data,
    output logic                   out_user
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_LEFT  = 4'b0010,
        B_RIGHT = 4'b0100,
        B_EMIT  = 4'b1000
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  samp_reg, samp_next;
    logic [SAMPLE_BITS-1:0]  right_mag_reg, right_mag_next;
    logic signed [DB_W-1:0]  dl_reg, dl_next;
    logic signed [DB_W-1:0]  dr_reg, dr_next;
    logic signed [DB_W-1:0]  held_left_reg, held_left_next;
    logic signed [DB_W-1:0]  held_right_reg, held_right_next;
    logic signed [DB_W-1:0]  held_loud_reg, held_loud_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;
    logic                    out_user_reg, out_user_next;

    logic                    e_upd;
    logic [SAMPLE_BITS-1:0]  e_right;
    logic [SAMPLE_BITS-1:0]  e_left;
    logic [SAMPLE_BITS-1:0]  e_samp;
    logic                    out_free;
    logic signed [DB_W-1:0]  loud_new;

    assign e_upd   = q_data[ENTRY_W-1];
    assign e_right = q_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign e_left  = q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign e_samp  = q_data[SAMPLE_BITS-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign loud_new = ((dl_reg > dr_reg) ? dl_reg : dr_reg) - LOUD_OFFSET;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    always_comb
    begin
        state_next      = state_reg;
        samp_next       = samp_reg;
        right_mag_next  = right_mag_reg;
        dl_next         = dl_reg;
        dr_next         = dr_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        held_loud_next  = held_loud_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        q_pop           = 1'b0;
        conv_start      = 1'b0;
        conv_mag        = e_left;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (e_upd)
                    begin
                        q_pop          = 1'b1;
                        conv_start     = 1'b1;
                        samp_next      = e_samp;
                        right_mag_next = e_right;
                        state_next     = B_LEFT;
                    end
                    else if (out_free)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_user_next  = 1'b0;
                        out_data_next  = OUT_W'({held_loud_reg, held_right_reg,
                                                 held_left_reg, e_samp});
                    end
                end
            end
            B_LEFT:
            begin
                conv_mag = right_mag_reg;
                if (conv_rsp.done)
                begin
                    dl_next    = conv_rsp.db;
                    conv_start = 1'b1;
                    state_next = B_RIGHT;
                end
            end
            B_RIGHT:
            begin
                if (conv_rsp.done)
                begin
                    dr_next    = conv_rsp.db;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    held_left_next  = dl_reg;
                    held_right_next = dr_reg;
                    held_loud_next  = loud_new;
                    out_valid_next  = 1'b1;
                    out_user_next   = 1'b1;
                    out_data_next   = OUT_W'({loud_new, dr_reg, dl_reg, samp_reg});
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            held_left_reg  <= DB_FLOOR;
            held_right_reg <= DB_FLOOR;
            held_loud_reg  <= DB_FLOOR - LOUD_OFFSET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            held_loud_reg  <= held_loud_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        right_mag_reg <= right_mag_next;
        dl_reg        <= dl_next;
        dr_reg        <= dr_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

endmodule

// ----- design/gpdm_checker.sv -----
module gpdm_checker
    import gpdm_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int OUT_W       = ((SAMPLE_BITS + 3 * DB_W + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    logic signed [DB_W-1:0] left_db;
    logic signed [DB_W-1:0] right_db;
    logic signed [DB_W-1:0] loud_db;
    logic signed [DB_W-1:0] max_db;
    logic signed [DB_W-1:0] last_left_reg;
    logic signed [DB_W-1:0] last_right_reg;
    logic signed [DB_W-1:0] last_loud_reg;

    assign left_db  = m_tdata[SAMPLE_BITS+DB_W-1:SAMPLE_BITS];
    assign right_db = m_tdata[SAMPLE_BITS+2*DB_W-1:SAMPLE_BITS+DB_W];
    assign loud_db  = m_tdata[SAMPLE_BITS+3*DB_W-1:SAMPLE_BITS+2*DB_W];
    assign max_db   = (left_db > right_db) ? left_db : right_db;

    // Meters last delivered with an update; plain items must repeat them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= DB_FLOOR;
            last_right_reg <= DB_FLOOR;
            last_loud_reg  <= DB_FLOOR - LOUD_OFFSET;
        end
        else if (m_tvalid && m_tready && m_tuser)
        begin
            last_left_reg  <= left_db;
            last_right_reg <= right_db;
            last_loud_reg  <= loud_db;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_loudness: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> loud_db == max_db - LOUD_OFFSET)
        else $error("loudness does not follow the larger peak");

    a_db_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> left_db <= 12'sd0 && left_db >= DB_MIN
                                && right_db <= 12'sd0 && right_db >= DB_MIN)
        else $error("meter value out of range");

    a_meters_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> left_db == last_left_reg && right_db == last_right_reg
                                 && loud_db == last_loud_reg)
        else $error("meters changed without an update");

endmodule

bind gain_and_peak_db_meter_top gpdm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gpdm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/gain_and_peak_db_meter_checker.sv -----
`timescale 1ns / 100ps

package gpdm_bench_pkg;

    typedef enum logic {
        REG_RUNNING     = 1'b0,
        REG_MASTER_GAIN = 1'b1
    } cfg_reg_e;

endpackage

module gain_and_peak_db_meter_checker
    import gpdm_pkg::*;
    import gpdm_bench_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int IN_W        = 32,
    parameter int OUT_W       = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // sample_in, channel_index
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // sample_out, left_peak_db, right_peak_db, loudness_db
    input  logic              m_tuser,   // meters_valid
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [GAIN_W-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    localparam int     SB              = SAMPLE_BITS;
    localparam longint SAMPLE_MAX      = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAMPLE_MIN      = -(longint'(1) << (SB - 1));
    localparam longint DB_PER_LOG2_Q16 = 6313057;
    localparam longint ROUND_HALF_Q32  = longint'(1) << 31;
    localparam logic [63:0] THRESH_SCALE = 64'd100000;
    localparam int     REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [SB-1:0]   sample;
        logic signed [DB_W-1:0] left;
        logic signed [DB_W-1:0] right;
        logic signed [DB_W-1:0] loud;
        logic                   valid;
    } meter_result_t;

    meter_result_t           expected_q[$];
    logic                    running_q;
    logic [GAIN_W-1:0]       gain_q;
    logic [SB-1:0]           left_peak;
    logic [SB-1:0]           right_peak;
    logic signed [DB_W-1:0]  held_left;
    logic signed [DB_W-1:0]  held_right;
    logic signed [DB_W-1:0]  held_loud;

    function automatic logic signed [DB_W-1:0] peak_to_db16(input logic [SB-1:0] mag);
        logic [63:0] wide;
        logic [63:0] x;
        logic [15:0] frac;
        int          e;
        longint      lq;
        longint      q;
        wide = 64'(mag);
        if (wide * THRESH_SCALE <= (64'd1 << (SB - 1)))
            return DB_FLOOR;
        e = 0;
        for (int i = 0; i < SB; i++)
            if (mag[i])
                e = i;
        x = wide << (31 - e);
        frac = '0;
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 31;
            frac = {frac[14:0], 1'b0};
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        lq = longint'(e - (SB - 1)) * 65536 + longint'(frac);
        if (lq >= 0)
            return '0;
        q = ((-lq) * DB_PER_LOG2_Q16 + ROUND_HALF_Q32) >>> 32;
        if (q > -longint'(DB_MIN))
            return DB_MIN;
        return DB_W'(-q);
    endfunction

    always @(posedge clk)
    begin
        logic signed [SB-1:0]   s;
        logic signed [SB-1:0]   y;
        logic [SB-1:0]          mag;
        logic [CH_W-1:0]        ch;
        logic [GAIN_W-1:0]      g;
        logic signed [DB_W-1:0] dl;
        logic signed [DB_W-1:0] dr;
        logic                   updated;
        longint                 prod;
        meter_result_t          want;
        meter_result_t          got;
        meter_result_t          oldest;
        if (!rst_n)
        begin
            expected_q.delete();
            running_q   = 1'b0;
            gain_q      = GAIN_RESET;
            left_peak   = '0;
            right_peak  = '0;
            held_left   = DB_FLOOR;
            held_right  = DB_FLOOR;
            held_loud   = DB_FLOOR - LOUD_OFFSET;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_e'(cfg_index))
                    REG_RUNNING:     running_q = cfg_data[0];
                    REG_MASTER_GAIN: gain_q    = cfg_data;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.sample = m_tdata[SB-1:0];
                got.left   = m_tdata[SB+DB_W-1:SB];
                got.right  = m_tdata[SB+2*DB_W-1:SB+DB_W];
                got.loud   = m_tdata[SB+3*DB_W-1:SB+2*DB_W];
                got.valid  = m_tuser;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result with none expected:", $realtime);
                        $display("  sample %0d left %0d right %0d loud %0d valid %0b",
                                 got.sample, got.left, got.right, got.loud, got.valid);
                    end
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (got !== oldest)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch:", $realtime);
                            $display("  expected sample %0d left %0d right %0d loud %0d valid %0b",
                                     oldest.sample, oldest.left, oldest.right,
                                     oldest.loud, oldest.valid);
                            $display("  actual   sample %0d left %0d right %0d loud %0d valid %0b",
                                     got.sample, got.left, got.right, got.loud, got.valid);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                s = s_tdata[SB-1:0];
                ch = s_tdata[SB+CH_W-1:SB];
                y = s;
                updated = 1'b0;
                if (running_q)
                begin
                    g = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
                    prod = (longint'(s) * longint'(g) + 8192) >>> 14;
                    if (prod > SAMPLE_MAX)
                        prod = SAMPLE_MAX;
                    else if (prod < SAMPLE_MIN)
                        prod = SAMPLE_MIN;
                    y = prod[SB-1:0];
                    mag = y[SB-1] ? (~y + 1'b1) : y;
                    if (ch == CH_LEFT && mag > left_peak)
                        left_peak = mag;
                    if (ch == CH_RIGHT && mag > right_peak)
                        right_peak = mag;
                    if (s_tlast)
                    begin
                        dl = peak_to_db16(left_peak);
                        dr = peak_to_db16(right_peak);
                        held_left  = dl;
                        held_right = dr;
                        held_loud  = ((dl > dr) ? dl : dr) - LOUD_OFFSET;
                        left_peak  = '0;
                        right_peak = '0;
                        updated    = 1'b1;
                    end
                end
                want.sample = y;
                want.left   = held_left;
                want.right  = held_right;
                want.loud   = held_loud;
                want.valid  = updated;
                expected_q.insert(expected_q.size(), want);
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ----- bench/gain_and_peak_db_meter_top_tb.sv -----
`timescale 1ns / 100ps

module gain_and_peak_db_meter_top_tb;
    import gpdm_pkg::*;
    import gpdm_bench_pkg::*;

    localparam int SB           = 24;
    localparam int IN_W         = ((SB + CH_W + 7) / 8) * 8;
    localparam int OUT_W        = ((SB + 3 * DB_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 160;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 6;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // sample_in, channel_index
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // sample_out, left_peak_db, right_peak_db, loudness_db
    logic              m_tuser;   // meters_valid
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    int   mismatches;
    int   outstanding;
    logic fast_mode = 1'b0;
    int   hold_requests = 0;
    int   holds_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    gain_and_peak_db_meter_top #(.SAMPLE_BITS(SB)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gain_and_peak_db_meter_checker #(
        .SAMPLE_BITS (SB),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) meter_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [GAIN_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_sample(input logic signed [SB-1:0] s, input logic [CH_W-1:0] ch,
                               input logic last);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = IN_W'({ch, s});
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        logic [SB-1:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r = SB'($urandom);
            4, 5:       r = SB'($urandom) >> $urandom_range(0, SB - 1);
            6:          r = $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
            7:          r = SB'($urandom_range(70, 100));
            default:    r = SB'($urandom_range(0, 16));
        endcase
        if ($urandom_range(0, 9) >= 6 && $urandom_range(0, 1) == 1)
            r = ~r + 1'b1;
        return r;
    endfunction

    task automatic send_random_block(output int count);
        int              len;
        logic [CH_W-1:0] ch;
        logic            last;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            ch = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(0, 1))
                                            : CH_W'($urandom_range(2, 7));
            last = (i == len - 1);
            if ($urandom_range(0, 19) == 0)
                last = ~last;
            send_sample(pick_sample(), ch, last);
        end
        count = len;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready   = 1'b0;
        holds_done = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            stall = fast_mode ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        int sent;
        int n;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_RUNNING;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Stopped after reset: pass-through, and a block end that must not touch the meters.
        send_sample(24'sh7FFFFF, 3'd0, 1'b1);
        send_sample(-24'sh800000, 3'd7, 1'b0);
        wait_idle();
        write_reg(REG_RUNNING, 16'd1);

        send_sample(-24'sh800000, CH_LEFT, 1'b0);
        send_sample(24'sh7FFFFF, CH_RIGHT, 1'b0);
        send_sample(24'sd5, 3'd2, 1'b0);
        send_sample(24'sd0, 3'd7, 1'b1);
        send_sample(24'sd83, CH_LEFT, 1'b0);
        send_sample(-24'sd84, CH_RIGHT, 1'b1);
        send_sample(24'sd0, CH_LEFT, 1'b1);

        wait_idle();
        write_reg(REG_MASTER_GAIN, 16'hFFFF);
        send_sample(24'sd4194304, CH_LEFT, 1'b0);
        send_sample(-24'sd4194305, CH_RIGHT, 1'b0);
        send_sample(24'sd3, 3'd6, 1'b1);

        wait_idle();
        write_reg(REG_MASTER_GAIN, 16'd0);
        send_sample(24'sh7FFFFF, CH_LEFT, 1'b1);

        wait_idle();
        write_reg(REG_MASTER_GAIN, 16'd1);
        send_sample(24'sd8192, CH_LEFT, 1'b0);
        send_sample(-24'sd8193, CH_RIGHT, 1'b1);

        wait_idle();
        write_reg(REG_MASTER_GAIN, GAIN_MAX);
        send_sample(-24'sh800000, CH_LEFT, 1'b0);
        send_sample(24'sd1, CH_RIGHT, 1'b1);

        wait_idle();
        write_reg(REG_RUNNING, 16'd0);
        send_sample(24'sd123, CH_RIGHT, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            write_reg(REG_RUNNING, (phase == 3) ? 16'd0 : 16'd1);
            case (phase)
                0:       write_reg(REG_MASTER_GAIN, GAIN_W'($urandom_range(12000, 20000)));
                2:       write_reg(REG_MASTER_GAIN, GAIN_MAX);
                4:       write_reg(REG_MASTER_GAIN, GAIN_W'($urandom_range(0, 32768)));
                5:       write_reg(REG_MASTER_GAIN, GAIN_W'($urandom_range(32769, 65535)));
                default: write_reg(REG_MASTER_GAIN, GAIN_W'($urandom));
            endcase
            fast_mode = (phase == 1 || phase == 4);
            if (phase == 2)
                hold_requests++;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_block(n);
                sent += n;
            end
        end

        s_tvalid = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/gpdm_pkg.sv
design/gpdm_front.sv
design/gpdm_queue.sv
design/gpdm_db_conv.sv
design/gpdm_back.sv
design/gain_and_peak_db_meter_top.sv
design/gpdm_checker.sv
bench/gain_and_peak_db_meter_checker.sv
bench/gain_and_peak_db_meter_top_tb.sv
